// ===== hdl/rita_pkg.sv =====
package rita_pkg;

  // default used width of the input value
  localparam int unsigned VALUE_BITS_DEF = 64;

  // digit store geometry
  localparam int unsigned DIGITS_MAX = 64;
  localparam int unsigned DIGIT_W    = 6;
  localparam int unsigned IDX_W      = $clog2(DIGITS_MAX);
  localparam int unsigned COUNT_W    = IDX_W + 1;

  // field widths
  localparam int unsigned IN_VALUE_W = 64;
  localparam int unsigned RADIX_W    = 6;
  localparam int unsigned CHAR_W     = 8;

  // radix limits
  localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(36);

  // character constants
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_LOWER = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_UPPER = 8'h41;
  localparam logic [DIGIT_W-1:0] DIGIT_TEN = DIGIT_W'(10);

  // control sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_RD,
    ST_LOAD,
    ST_OUT
  } rita_state_t;

  // divider status seen by the sequencer
  typedef struct packed {
    logic               done;
    logic [DIGIT_W-1:0] remainder;
  } div_status_t;

  // digit value to ascii character
  function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d,
                                                      input logic upper);
    logic [CHAR_W-1:0] base_char;
    base_char = upper ? CHAR_UPPER : CHAR_LOWER;
    if (d >= DIGIT_TEN) begin
      return base_char + CHAR_W'(d - DIGIT_TEN);
    end
    return CHAR_ZERO + CHAR_W'(d);
  endfunction

endpackage

// ===== hdl/radix_integer_to_ascii.sv =====
// Each digit comes from the bit-serial divider, one quotient bit per cycle; then each digit is
// read back from the digit store and handed out through the read, load and output states.
// Throughput: one value at a time; a new value is not taken until its last digit is out.
// The input is stalled from acceptance until the last digit has been transferred.
// Reset (synchronous, active low) clears the sequencer, digit count and output valid;
// the digit store is not cleared.
module radix_integer_to_ascii
  import rita_pkg::*;
  #(parameter int unsigned VALUE_BITS = VALUE_BITS_DEF)
  (input  logic                  clk,
   input  logic                  rst_n,
   input  logic                  in_valid,
   output logic                  in_stall,
   input  logic [IN_VALUE_W-1:0] in_value,
   input  logic [RADIX_W-1:0]    in_radix,
   input  logic                  in_upper_case,
   output logic                  out_valid,
   input  logic                  out_stall,
   output logic [CHAR_W-1:0]     out_digit_char,
   output logic                  out_last_digit);

  rita_state_t state_r, state_nxt;

  logic [COUNT_W-1:0]    cnt_r, cnt_nxt;
  logic [IDX_W-1:0]      idx_r, idx_nxt;
  logic [RADIX_W-1:0]    radix_r, radix_nxt;
  logic                  upper_r, upper_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]     out_char_r, out_char_nxt;
  logic                  out_last_r, out_last_nxt;

  logic                  div_start;
  logic [VALUE_BITS-1:0] div_dividend;
  logic [VALUE_BITS-1:0] div_quotient;
  div_status_t           div_status;
  logic                  store_we;
  logic [DIGIT_W-1:0]    store_rd_data;
  logic [RADIX_W-1:0]    radix_sat;

  // saturate the base to the supported range
  always_comb begin
    priority if (in_radix < RADIX_MIN) begin
      radix_sat = RADIX_MIN;
    end else if (in_radix > RADIX_MAX) begin
      radix_sat = RADIX_MAX;
    end else begin
      radix_sat = in_radix;
    end
  end

  // first division takes the input, later ones the previous quotient
  assign div_dividend = (state_r == ST_IDLE) ? in_value[VALUE_BITS-1:0] : div_quotient;

  rita_divider #(.VALUE_BITS(VALUE_BITS)) u_divider (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (state_r == ST_IDLE ? radix_sat : radix_r),
    .quotient (div_quotient),
    .status   (div_status)
  );

  rita_ram #(.WIDTH(DIGIT_W), .DEPTH(DIGITS_MAX)) u_digit_store (
    .clk     (clk),
    .wr_en   (store_we),
    .wr_addr (cnt_r[IDX_W-1:0]),
    .wr_data (div_status.remainder),
    .rd_addr (idx_r),
    .rd_data (store_rd_data)
  );

  // sequencer: divide into the store, then read back most significant first
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    radix_nxt     = radix_r;
    upper_nxt     = upper_r;
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    div_start     = 1'b0;
    store_we      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          radix_nxt = radix_sat;
          upper_nxt = in_upper_case;
          cnt_nxt   = '0;
          div_start = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_status.done) begin
          store_we = 1'b1;
          cnt_nxt  = cnt_r + COUNT_W'(1);
          if (div_quotient != '0 && cnt_r < COUNT_W'(DIGITS_MAX - 1)) begin
            div_start = 1'b1;
          end else begin
            idx_nxt   = cnt_r[IDX_W-1:0];
            state_nxt = ST_RD;
          end
        end
      end
      ST_RD: begin
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        out_valid_nxt = 1'b1;
        out_char_nxt  = digit_to_char(store_rd_data, upper_r);
        out_last_nxt  = (idx_r == '0);
        state_nxt     = ST_OUT;
      end
      ST_OUT: begin
        if (!out_stall) begin
          out_valid_nxt = 1'b0;
          if (idx_r == '0) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt   = idx_r - IDX_W'(1);
            state_nxt = ST_RD;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    radix_r    <= radix_nxt;
    upper_r    <= upper_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign in_stall       = (state_r != ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_digit_char = out_char_r;
  assign out_last_digit = out_last_r;

endmodule

// ===== hdl/rita_ram.sv =====
module rita_ram
  #(parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64)
  (input  logic                     clk,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hdl/rita_divider.sv =====
module rita_divider
  import rita_pkg::*;
  #(parameter int unsigned VALUE_BITS = VALUE_BITS_DEF)
  (input  logic                  clk,
   input  logic                  rst_n,
   input  logic                  start,
   input  logic [VALUE_BITS-1:0] dividend,
   input  logic [RADIX_W-1:0]    divisor,
   output logic [VALUE_BITS-1:0] quotient,
   output div_status_t           status);

  localparam int unsigned CNT_W = $clog2(VALUE_BITS);

  logic [VALUE_BITS-1:0] quo_r, quo_nxt;
  logic [DIGIT_W-1:0]    rem_r, rem_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [DIGIT_W:0]      trial;
  logic                  fits;

  // one restoring step: bring down the next dividend bit
  assign trial = {rem_r, quo_r[VALUE_BITS-1]};
  assign fits  = trial >= {1'b0, divisor};

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      cnt_nxt  = CNT_W'(VALUE_BITS - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      quo_nxt = {quo_r[VALUE_BITS-2:0], fits};
      rem_nxt = fits ? DIGIT_W'(trial - {1'b0, divisor}) : DIGIT_W'(trial);
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
  end

  assign quotient         = quo_r;
  assign status.done      = done_r;
  assign status.remainder = rem_r;

endmodule

// ===== dv/rita_digit_checker.sv =====
module rita_digit_checker
  import rita_pkg::*;
  #(parameter int unsigned VALUE_BITS = VALUE_BITS_DEF)
  (input  logic                  clk,
   input  logic                  rst_n,
   input  logic                  in_valid,
   input  logic                  in_stall,
   input  logic [IN_VALUE_W-1:0] in_value,
   input  logic [RADIX_W-1:0]    in_radix,
   input  logic                  in_upper_case,
   input  logic                  out_valid,
   input  logic                  out_stall,
   input  logic [CHAR_W-1:0]     out_digit_char,
   input  logic                  out_last_digit,
   output int                    errors,
   output int                    digits_pending,
   output int                    values_seen,
   output int                    digits_seen);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [CHAR_W-1:0] digit_char;
    logic              last_digit;
  } ascii_digit_t;

  // characters still owed by the block, oldest first
  ascii_digit_t expected_chars[$];

  localparam logic [IN_VALUE_W-1:0] USED_MASK = {IN_VALUE_W{1'b1}} >> (IN_VALUE_W - VALUE_BITS);

  // convert one value and queue its characters, most significant first
  function automatic void queue_digits(input logic [IN_VALUE_W-1:0] value,
                                       input logic [RADIX_W-1:0]    radix,
                                       input logic                  upper);
    logic [IN_VALUE_W-1:0] rest;
    logic [IN_VALUE_W-1:0] base;
    logic [DIGIT_W-1:0]    digits [DIGITS_MAX];
    logic [CHAR_W-1:0]     alpha;
    ascii_digit_t          entry;
    int                    n;
    rest  = value & USED_MASK;
    // base saturates to the legal range
    if (radix < RADIX_MIN) begin
      base = IN_VALUE_W'(RADIX_MIN);
    end else if (radix > RADIX_MAX) begin
      base = IN_VALUE_W'(RADIX_MAX);
    end else begin
      base = IN_VALUE_W'(radix);
    end
    alpha = upper ? CHAR_UPPER : CHAR_LOWER;
    n = 0;
    do begin
      digits[n] = DIGIT_W'(rest % base);
      rest = rest / base;
      n++;
    end while (rest != 0 && n < DIGITS_MAX);
    for (int k = n - 1; k >= 0; k--) begin
      if (digits[k] >= DIGIT_TEN) begin
        entry.digit_char = alpha + CHAR_W'(digits[k] - DIGIT_TEN);
      end else begin
        entry.digit_char = CHAR_ZERO + CHAR_W'(digits[k]);
      end
      entry.last_digit = (k == 0);
      expected_chars.push_back(entry);
    end
  endfunction

  // watch both channels on the rising edge
  always @(posedge clk) begin
    ascii_digit_t want;
    if (!rst_n) begin
      expected_chars.delete();
    end else begin
      // result transfer: compare against the oldest expectation
      if (out_valid && !out_stall) begin
        digits_seen++;
        if (expected_chars.size() == 0) begin
          $error("unexpected digit transfer: digit_char %h last_digit %b",
                 out_digit_char, out_last_digit);
          errors++;
        end else begin
          want = expected_chars.pop_front();
          if (out_digit_char !== want.digit_char) begin
            $error("digit_char mismatch: expected %h actual %h",
                   want.digit_char, out_digit_char);
            errors++;
          end
          if (out_last_digit !== want.last_digit) begin
            $error("last_digit mismatch: expected %b actual %b",
                   want.last_digit, out_last_digit);
            errors++;
          end
        end
      end
      // input transfer: predict its digits
      if (in_valid && !in_stall) begin
        values_seen++;
        queue_digits(in_value, in_radix, in_upper_case);
      end
    end
    digits_pending = expected_chars.size();
  end

endmodule

// ===== dv/radix_integer_to_ascii_tb.sv =====
module radix_integer_to_ascii_tb
  import rita_pkg::*;
  ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RANDOM_VALUES = 200;
  localparam int unsigned CYCLE_LIMIT   = 5000000;
  localparam int unsigned DRAIN_LIMIT   = 20000;
  localparam int unsigned TAIL_CYCLES   = 200;

  logic                  clk           = 1'b0;
  logic                  rst_n         = 1'b0;
  logic                  in_valid      = 1'b0;
  logic                  in_stall;
  logic [IN_VALUE_W-1:0] in_value      = '0;
  logic [RADIX_W-1:0]    in_radix      = '0;
  logic                  in_upper_case = 1'b0;
  logic                  out_valid;
  logic                  out_stall     = 1'b0;
  logic [CHAR_W-1:0]     out_digit_char;
  logic                  out_last_digit;

  int errors;
  int digits_pending;
  int values_seen;
  int digits_seen;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int cycles        = 0;
  int drain_wait;

  radix_integer_to_ascii #(.VALUE_BITS(VALUE_BITS_DEF)) uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_value      (in_value),
    .in_radix      (in_radix),
    .in_upper_case (in_upper_case),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_digit_char(out_digit_char),
    .out_last_digit(out_last_digit));

  rita_digit_checker #(.VALUE_BITS(VALUE_BITS_DEF)) checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_value      (in_value),
    .in_radix      (in_radix),
    .in_upper_case (in_upper_case),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_digit_char(out_digit_char),
    .out_last_digit(out_last_digit),
    .errors        (errors),
    .digits_pending(digits_pending),
    .values_seen   (values_seen),
    .digits_seen   (digits_seen));

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // receiver back-pressure
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[radix_integer_to_ascii] ERROR");
      $finish;
    end
  end

  // one value transfer, entered and left at a falling edge
  task automatic send_value(input logic [IN_VALUE_W-1:0] value,
                            input logic [RADIX_W-1:0]    radix,
                            input logic                  upper);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_value      <= value;
    in_radix      <= radix;
    in_upper_case <= upper;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // random value of random magnitude in a mostly legal base
  task automatic send_random_value();
    logic [IN_VALUE_W-1:0] value;
    logic [RADIX_W-1:0]    radix;
    int                    pick;
    value = {$urandom, $urandom};
    pick  = $urandom_range(99);
    if (pick < 5) begin
      value = '0;
    end else if (pick >= 20) begin
      value = value >> $urandom_range(63);
    end
    if ($urandom_range(99) < 80) begin
      radix = RADIX_W'($urandom_range(int'(RADIX_MAX), int'(RADIX_MIN)));
    end else begin
      radix = RADIX_W'($urandom_range(63));
    end
    send_value(value, radix, 1'($urandom_range(1)));
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed cases under the first idle pattern
    send_idle_pct = 31;
    recv_idle_pct = 66;
    send_value('0, 6'd10, 1'b0);
    send_value('0, 6'd63, 1'b1);
    send_value('0, 6'd0, 1'b0);
    send_value('1, RADIX_MIN, 1'b0);
    send_value('1, RADIX_MAX, 1'b0);
    send_value('1, RADIX_MAX, 1'b1);
    send_value(64'h8000_0000_0000_0000, 6'd16, 1'b1);
    send_value(64'hFEDC_BA98_7654_3210, 6'd16, 1'b0);
    send_value(64'd35, RADIX_MAX, 1'b0);
    send_value(64'd35, RADIX_MAX, 1'b1);
    send_value(64'd1, RADIX_MIN, 1'b0);
    send_value(64'd5, 6'd0, 1'b0);
    send_value(64'd6, 6'd1, 1'b1);
    send_value(64'd1295, 6'd37, 1'b1);
    send_value(64'd1296, 6'd63, 1'b0);
    send_value(64'd9, 6'd10, 1'b0);
    send_value(64'd10, 6'd11, 1'b1);
    send_value(64'd10, 6'd11, 1'b0);
    send_value(64'd123456789, 6'd10, 1'b0);

    // random values under three idle patterns
    for (int i = 0; i < RANDOM_VALUES; i++) begin
      if (i == RANDOM_VALUES / 3) begin
        send_idle_pct = 66;
        recv_idle_pct = 31;
      end else if (i == 2 * RANDOM_VALUES / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      send_random_value();
    end
    in_valid <= 1'b0;

    // drain outstanding digits, then watch for stray transfers
    drain_wait = 0;
    while (digits_pending != 0 && drain_wait < DRAIN_LIMIT) begin
      @(negedge clk);
      drain_wait++;
    end
    if (digits_pending != 0) begin
      $error("%0d expected digits never arrived", digits_pending);
    end
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("covered %0d values and %0d digit transfers, bases 2 to 36 with saturation,",
             values_seen, digits_seen);
    $display("zero, full-width and both letter cases under three idle patterns");
    if (errors == 0 && digits_pending == 0) begin
      $display("[radix_integer_to_ascii] OK");
    end else begin
      $display("[radix_integer_to_ascii] ERROR");
    end
    $finish;
  end

endmodule

// ===== radix_integer_to_ascii.f =====
hdl/rita_pkg.sv
hdl/rita_ram.sv
hdl/rita_divider.sv
hdl/radix_integer_to_ascii.sv
dv/rita_digit_checker.sv
dv/radix_integer_to_ascii_tb.sv
